/* src/orp_pkg.sv */
`default_nettype none

package orp_pkg;

    // parse phase codes
    localparam logic [1:0] PH_OPCODE      = 2'd0;
    localparam logic [1:0] PH_COUNT       = 2'd1;
    localparam logic [1:0] PH_VALUE       = 2'd2;
    localparam logic [1:0] PH_PAIR_SECOND = 2'd3;

    // event kinds
    localparam logic [3:0] EV_BODY    = 4'd0;
    localparam logic [3:0] EV_MODEL   = 4'd1;
    localparam logic [3:0] EV_NOSEL   = 4'd2;
    localparam logic [3:0] EV_RECOLOR = 4'd3;
    localparam logic [3:0] EV_RETEX   = 4'd4;
    localparam logic [3:0] EV_SLOT    = 4'd5;
    localparam logic [3:0] EV_END     = 4'd6;
    localparam logic [3:0] EV_BUFEND  = 4'd7;
    localparam logic [3:0] EV_UNKNOWN = 4'd8;
    localparam logic [3:0] EV_TRUNC   = 4'd9;

    // opcodes
    localparam logic [7:0] OP_END          = 8'd0;
    localparam logic [7:0] OP_BODY         = 8'd1;
    localparam logic [7:0] OP_MODEL16      = 8'd2;
    localparam logic [7:0] OP_NOSEL        = 8'd3;
    localparam logic [7:0] OP_MODEL32      = 8'd5;
    localparam logic [7:0] OP_RECOLOR      = 8'd40;
    localparam logic [7:0] OP_RETEX        = 8'd41;
    localparam logic [7:0] OP_SLOT16_FIRST = 8'd60;
    localparam logic [7:0] OP_SLOT16_LAST  = 8'd69;
    localparam logic [7:0] OP_SLOT32_FIRST = 8'd70;
    localparam logic [7:0] OP_SLOT32_LAST  = 8'd79;

    typedef struct packed {
        logic [1:0]  phase;
        logic [6:0]  opcode;
        logic [1:0]  byte_in_value;
        logic [31:0] acc;
        logic [15:0] pair_first;
        logic [7:0]  elements_left;
        logic [7:0]  element_position;
        logic [7:0]  count_seen;
        logic        halted;
    } t_state;

    typedef struct packed {
        logic [3:0]         event_kind;
        logic [7:0]         item_index;
        logic [7:0]         list_length;
        logic signed [31:0] value_first;
        logic [15:0]        value_second;
        logic [15:0]        bytes_consumed;
    } t_event;

endpackage

`default_nettype wire

/* src/orp_rec_if.sv */
`default_nettype none

interface orp_rec_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

`default_nettype wire

/* src/orp_evt_if.sv */
`default_nettype none

interface orp_evt_if;
    logic               valid;
    logic               ready;
    logic [3:0]         event_kind;
    logic [7:0]         item_index;
    logic [7:0]         list_length;
    logic signed [31:0] value_first;
    logic [15:0]        value_second;
    logic [15:0]        bytes_consumed;

    modport source (output valid, event_kind, item_index, list_length, value_first,
                    value_second, bytes_consumed, input ready);
    modport sink   (input valid, event_kind, item_index, list_length, value_first,
                    value_second, bytes_consumed, output ready);
endinterface

`default_nettype wire

/* src/orp_step.sv */
`default_nettype none

module orp_step import orp_pkg::*; #(
    parameter int POSITION_BITS = 16
) (
    input  wire t_state                   i_state,
    input  wire logic [POSITION_BITS-1:0] i_pos,
    input  wire logic [7:0]               i_data_byte,
    input  wire logic                     i_first_byte,
    input  wire logic                     i_last_byte,
    output t_state                        o_state,
    output logic [POSITION_BITS-1:0]      o_pos,
    output logic                          o_evt_valid,
    output t_event                        o_evt
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    t_state                   st;
    logic [POSITION_BITS-1:0] pos;
    t_event                   ev;
    logic                     ev_valid;
    logic                     stop;
    logic [31:0]              pos_ext;
    logic [15:0]              rpt;
    logic [31:0]              acc_new;
    logic [2:0]               vw;
    logic [2:0]               biv_inc;
    logic [7:0]               op8;
    logic                     is_list;
    logic [7:0]               b;

    always_comb begin
        st       = i_state;
        pos      = i_pos;
        ev       = '0;
        ev_valid = 1'b0;
        stop     = 1'b0;
        b        = i_data_byte;
        op8      = {1'b0, i_state.opcode};
        acc_new  = '0;
        vw       = 3'd2;
        biv_inc  = '0;
        is_list  = 1'b0;
        pos_ext  = '0;
        rpt      = '0;

        if (i_first_byte) begin
            st  = '0;
            pos = '0;
        end

        if (!st.halted) begin
            if (pos != POS_MAX) begin
                pos = pos + 1'b1;
            end
            pos_ext = 32'(pos);
            rpt     = (pos_ext > 32'h0000_FFFF) ? 16'hFFFF : pos_ext[15:0];

            case (st.phase)
                PH_OPCODE: begin
                    st.opcode = b[6:0];
                    if (b == OP_END) begin
                        ev.event_kind     = EV_END;
                        ev.bytes_consumed = rpt;
                        ev_valid          = 1'b1;
                        st.halted         = 1'b1;
                        stop              = 1'b1;
                    end else if (b == OP_BODY ||
                                 (b >= OP_SLOT16_FIRST && b <= OP_SLOT32_LAST)) begin
                        st.phase         = PH_VALUE;
                        st.byte_in_value = '0;
                        st.acc           = '0;
                    end else if (b == OP_MODEL16 || b == OP_MODEL32 ||
                                 b == OP_RECOLOR || b == OP_RETEX) begin
                        st.phase = PH_COUNT;
                    end else if (b == OP_NOSEL) begin
                        ev.event_kind = EV_NOSEL;
                        ev_valid      = 1'b1;
                    end else begin
                        ev.event_kind     = EV_UNKNOWN;
                        ev.bytes_consumed = rpt;
                        ev_valid          = 1'b1;
                        st.halted         = 1'b1;
                        stop              = 1'b1;
                    end
                end
                PH_COUNT: begin
                    st.count_seen       = b;
                    st.elements_left    = b;
                    st.element_position = '0;
                    if (b == 8'd0) begin
                        st.phase = PH_OPCODE;
                    end else begin
                        st.phase         = PH_VALUE;
                        st.byte_in_value = '0;
                        st.acc           = '0;
                    end
                end
                default: begin
                    acc_new = {st.acc[23:0], b};
                    st.acc  = acc_new;
                    if (op8 == OP_BODY) begin
                        vw = 3'd1;
                    end else if (op8 == OP_MODEL32 ||
                                 (op8 >= OP_SLOT32_FIRST && op8 <= OP_SLOT32_LAST)) begin
                        vw = 3'd4;
                    end else begin
                        vw = 3'd2;
                    end
                    is_list = (op8 == OP_MODEL16 || op8 == OP_MODEL32 ||
                               op8 == OP_RECOLOR || op8 == OP_RETEX);
                    biv_inc = {1'b0, st.byte_in_value} + 3'd1;

                    if (biv_inc < vw) begin
                        st.byte_in_value = biv_inc[1:0];
                    end else if ((op8 == OP_RECOLOR || op8 == OP_RETEX) &&
                                 st.phase == PH_VALUE) begin
                        // first half of a pair; hold it for the second value
                        st.pair_first    = acc_new[15:0];
                        st.phase         = PH_PAIR_SECOND;
                        st.byte_in_value = '0;
                        st.acc           = '0;
                    end else begin
                        ev_valid = 1'b1;
                        if (op8 == OP_BODY) begin
                            ev.event_kind  = EV_BODY;
                            ev.value_first = $signed(acc_new);
                        end else if (op8 == OP_MODEL16 || op8 == OP_MODEL32) begin
                            ev.event_kind  = EV_MODEL;
                            ev.item_index  = st.element_position;
                            ev.list_length = st.count_seen;
                            ev.value_first = $signed(acc_new);
                        end else if (op8 == OP_RECOLOR || op8 == OP_RETEX) begin
                            ev.event_kind   = (op8 == OP_RECOLOR) ? EV_RECOLOR : EV_RETEX;
                            ev.item_index   = st.element_position;
                            ev.list_length  = st.count_seen;
                            ev.value_first  = $signed({16'd0, st.pair_first});
                            ev.value_second = acc_new[15:0];
                        end else begin
                            ev.event_kind  = EV_SLOT;
                            ev.item_index  = (op8 >= OP_SLOT32_FIRST) ?
                                             op8 - OP_SLOT32_FIRST : op8 - OP_SLOT16_FIRST;
                            ev.value_first = $signed(acc_new);
                        end

                        if (is_list) begin
                            st.element_position = st.element_position + 8'd1;
                            st.elements_left    = st.elements_left - 8'd1;
                            if (st.elements_left == 8'd0) begin
                                st.phase = PH_OPCODE;
                            end else begin
                                st.phase         = PH_VALUE;
                                st.byte_in_value = '0;
                                st.acc           = '0;
                            end
                        end else begin
                            st.phase = PH_OPCODE;
                        end
                    end
                end
            endcase

            // final byte of the buffer closes the record
            if (i_last_byte && !stop) begin
                st.halted = 1'b1;
                if (ev_valid) begin
                    ev.bytes_consumed = rpt;
                end else begin
                    ev.event_kind     = (st.phase == PH_OPCODE) ? EV_BUFEND : EV_TRUNC;
                    ev.bytes_consumed = rpt;
                    ev_valid          = 1'b1;
                end
            end
        end

        o_state     = st;
        o_pos       = pos;
        o_evt       = ev;
        o_evt_valid = ev_valid;
    end

endmodule

`default_nettype wire

/* src/opcode_record_parser.sv */
// Opcode record parser.
// Input channel i_rec carries one record byte per transaction, with first_byte
// marking the start of a record and last_byte the final byte of the buffer.
// Output channel o_evt carries at most one decoded event per input byte: field
// values, list elements with index and count, or an end event with the number
// of bytes consumed. After an end, bytes are dropped until the next first_byte.
// Each event is held in the output register, loaded when its byte is taken.
// Throughput: one byte per cycle while i_rec.ready is high; the parser state and
// the event register both update in the cycle the byte is taken.
// The output is a single register: i_rec.ready is high while that register is
// empty or is being drained, so a stalled receiver holds the event and stops
// input only until it takes it.
// Reset (i_rst_n low at a clock edge) clears the parser state and empties the
// output register; bytes that follow without first_byte start a fresh record.
// POSITION_BITS sets the width of the internal byte counter, which saturates;
// the reported count saturates at 65535.
`default_nettype none

module opcode_record_parser import orp_pkg::*; #(
    parameter int POSITION_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    orp_rec_if.sink    i_rec,
    orp_evt_if.source  o_evt
);

    t_state                   r_state;
    t_state                   n_state;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] n_pos;
    logic                     r_evt_valid;
    t_event                   r_evt;
    t_event                   step_evt;
    logic                     step_valid;
    logic                     rec_acc;

    assign i_rec.ready = !r_evt_valid || o_evt.ready;
    assign rec_acc     = i_rec.valid && i_rec.ready;

    orp_step #(
        .POSITION_BITS(POSITION_BITS)
    ) u_step (
        .i_state      (r_state),
        .i_pos        (r_pos),
        .i_data_byte  (i_rec.data_byte),
        .i_first_byte (i_rec.first_byte),
        .i_last_byte  (i_rec.last_byte),
        .o_state      (n_state),
        .o_pos        (n_pos),
        .o_evt_valid  (step_valid),
        .o_evt        (step_evt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_pos       <= '0;
            r_evt_valid <= 1'b0;
        end else begin
            if (rec_acc) begin
                r_state     <= n_state;
                r_pos       <= n_pos;
                r_evt_valid <= step_valid;
            end else if (o_evt.ready) begin
                r_evt_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rec_acc && step_valid) begin
            r_evt <= step_evt;
        end
    end

    assign o_evt.valid          = r_evt_valid;
    assign o_evt.event_kind     = r_evt.event_kind;
    assign o_evt.item_index     = r_evt.item_index;
    assign o_evt.list_length    = r_evt.list_length;
    assign o_evt.value_first    = r_evt.value_first;
    assign o_evt.value_second   = r_evt.value_second;
    assign o_evt.bytes_consumed = r_evt.bytes_consumed;

`ifndef ASSERT_OFF
    // a halted parser drops bytes silently until a new record starts
    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rec_acc && r_state.halted && !i_rec.first_byte |=> !r_evt_valid)
        else $error("event produced while halted");

    // the final byte of a live record always yields an event and halts
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rec_acc && i_rec.last_byte && (!r_state.halted || i_rec.first_byte)
        |=> r_state.halted && r_evt_valid)
        else $error("final byte did not close the record");

    // record end events always count at least the byte that ended them
    a_end_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_evt_valid && (r_evt.event_kind == EV_END || r_evt.event_kind == EV_BUFEND ||
                        r_evt.event_kind == EV_UNKNOWN || r_evt.event_kind == EV_TRUNC)
        |-> r_evt.bytes_consumed != 16'd0)
        else $error("end event with zero byte count");

    // only pair lists reach the second value of a pair
    a_pair_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_PAIR_SECOND
        |-> ({1'b0, r_state.opcode} == OP_RECOLOR || {1'b0, r_state.opcode} == OP_RETEX))
        else $error("pair phase under a non-pair opcode");
`endif

endmodule

`default_nettype wire

/* bench/opcode_record_parser_test.sv */
`timescale 1ns / 100ps

module opcode_record_parser_test;
    import orp_pkg::*;

    localparam int HOLD_OFF_CYCLES = 120;
    localparam int DRAIN_CYCLES    = 10;
    localparam int RANDOM_BYTES    = 1440;

    typedef enum {GAPS_NORMAL, GAPS_NONE, GAPS_CALM} t_gap_mode;

    typedef struct {
        logic [7:0] data;
        bit         first;
        bit         last;
        bit         known;
        bit         has_ev;
        t_event     ev;
    } t_script_row;

    logic clk;
    logic rst_n;

    orp_rec_if rec_ch();
    orp_evt_if evt_ch();

    opcode_record_parser i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rec   (rec_ch),
        .o_evt   (evt_ch)
    );

    // side info travelling with the byte on the input channel
    bit        in_known;
    bit        in_has_ev;
    t_event    in_ev;

    t_event      pending_events[$];
    t_script_row script_q[$];
    t_state      dec_st;
    logic [15:0] dec_pos;
    int          parsed_bytes;
    int          n_fail;
    t_gap_mode   gap_mode;
    bit          hold_off_req;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #(40_000_000);
        $display("[opcode_record_parser] ERROR");
        $finish;
    end

    function automatic t_event make_event(logic [3:0] kind, logic [7:0] idx, logic [7:0] len,
                                          logic [31:0] v1, logic [15:0] v2, logic [15:0] used);
        t_event ev;
        ev.event_kind     = kind;
        ev.item_index     = idx;
        ev.list_length    = len;
        ev.value_first    = v1;
        ev.value_second   = v2;
        ev.bytes_consumed = used;
        return ev;
    endfunction

    function automatic int value_bytes(logic [6:0] op);
        if (op == OP_BODY) return 1;
        if (op == OP_MODEL32 || (op >= OP_SLOT32_FIRST && op <= OP_SLOT32_LAST)) return 4;
        return 2;
    endfunction

    function automatic bit is_list(logic [7:0] op);
        return op == OP_MODEL16 || op == OP_MODEL32 || op == OP_RECOLOR || op == OP_RETEX;
    endfunction

    function automatic void open_value();
        dec_st.phase         = PH_VALUE;
        dec_st.byte_in_value = '0;
        dec_st.acc           = '0;
    endfunction

    // Predicts the event (if any) for one accepted byte and advances the state.
    function automatic void decode_byte(input logic [7:0] b, input bit first, input bit last,
                                        output bit fired, output t_event ev);
        logic [6:0] op;
        fired = 1'b0;
        ev    = '0;
        if (first) begin
            dec_st       = '0;
            dec_st.phase = PH_OPCODE;
            dec_pos      = '0;
        end
        if (dec_st.halted) return;
        if (dec_pos != 16'hFFFF) dec_pos++;
        case (dec_st.phase)
            PH_OPCODE: begin
                dec_st.opcode = b[6:0];
                if (b == OP_END) begin
                    ev = make_event(EV_END, 0, 0, 0, 0, dec_pos);
                    fired = 1'b1;
                    dec_st.halted = 1'b1;
                    return;
                end else if (b == OP_BODY || (b >= OP_SLOT16_FIRST && b <= OP_SLOT32_LAST)) begin
                    open_value();
                end else if (is_list(b)) begin
                    dec_st.phase = PH_COUNT;
                end else if (b == OP_NOSEL) begin
                    ev = make_event(EV_NOSEL, 0, 0, 0, 0, 0);
                    fired = 1'b1;
                end else begin
                    ev = make_event(EV_UNKNOWN, 0, 0, 0, 0, dec_pos);
                    fired = 1'b1;
                    dec_st.halted = 1'b1;
                    return;
                end
            end
            PH_COUNT: begin
                dec_st.count_seen       = b;
                dec_st.elements_left    = b;
                dec_st.element_position = '0;
                if (b == 8'd0) dec_st.phase = PH_OPCODE;
                else open_value();
            end
            default: begin
                op = dec_st.opcode;
                dec_st.acc = {dec_st.acc[23:0], b};
                if (dec_st.byte_in_value + 1 < value_bytes(op)) begin
                    dec_st.byte_in_value++;
                end else if ((op == OP_RECOLOR || op == OP_RETEX) && dec_st.phase == PH_VALUE) begin
                    // first half of a pair, hold it until the second arrives
                    dec_st.pair_first    = dec_st.acc[15:0];
                    dec_st.phase         = PH_PAIR_SECOND;
                    dec_st.byte_in_value = '0;
                    dec_st.acc           = '0;
                end else begin
                    fired = 1'b1;
                    if (op == OP_BODY)
                        ev = make_event(EV_BODY, 0, 0, dec_st.acc, 0, 0);
                    else if (op == OP_MODEL16 || op == OP_MODEL32)
                        ev = make_event(EV_MODEL, dec_st.element_position, dec_st.count_seen,
                                        dec_st.acc, 0, 0);
                    else if (op == OP_RECOLOR || op == OP_RETEX)
                        ev = make_event(op == OP_RECOLOR ? EV_RECOLOR : EV_RETEX,
                                        dec_st.element_position, dec_st.count_seen,
                                        {16'd0, dec_st.pair_first}, dec_st.acc[15:0], 0);
                    else
                        ev = make_event(EV_SLOT, op >= OP_SLOT32_FIRST ? op - OP_SLOT32_FIRST
                                                                        : op - OP_SLOT16_FIRST,
                                        0, dec_st.acc, 0, 0);
                    if (is_list({1'b0, op})) begin
                        dec_st.element_position++;
                        dec_st.elements_left--;
                        if (dec_st.elements_left == 8'd0) dec_st.phase = PH_OPCODE;
                        else open_value();
                    end else begin
                        dec_st.phase = PH_OPCODE;
                    end
                end
            end
        endcase
        if (last) begin
            dec_st.halted = 1'b1;
            if (fired) begin
                ev.bytes_consumed = dec_pos;
            end else begin
                ev = make_event(dec_st.phase == PH_OPCODE ? EV_BUFEND : EV_TRUNC,
                                0, 0, 0, 0, dec_pos);
                fired = 1'b1;
            end
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge clk) begin : monitor
        t_event want;
        t_event guess;
        bit     fired;
        if (!rst_n) begin
            dec_st       = '0;
            dec_st.phase = PH_OPCODE;
            dec_pos      = '0;
        end else begin
            if (evt_ch.valid && evt_ch.ready) begin
                if (pending_events.size() == 0) begin
                    $error("unexpected event: kind %0d, value 0x%0h",
                           evt_ch.event_kind, evt_ch.value_first);
                    n_fail++;
                end else begin
                    want = pending_events.pop_front();
                    check_field("event_kind", want.event_kind, evt_ch.event_kind);
                    check_field("item_index", want.item_index, evt_ch.item_index);
                    check_field("list_length", want.list_length, evt_ch.list_length);
                    check_field("value_first", want.value_first, evt_ch.value_first);
                    check_field("value_second", want.value_second, evt_ch.value_second);
                    check_field("bytes_consumed", want.bytes_consumed, evt_ch.bytes_consumed);
                end
            end
            if (rec_ch.valid && rec_ch.ready) begin
                if (rec_ch.first_byte || !dec_st.halted) parsed_bytes++;
                decode_byte(rec_ch.data_byte, rec_ch.first_byte, rec_ch.last_byte, fired, guess);
                if (in_known) begin
                    fired = in_has_ev;
                    guess = in_ev;
                end
                if (fired) pending_events.push_back(guess);
            end
        end
    end

    // receiver: ready in stretches, with an occasional long hold-off on request
    initial begin : receiver
        int r;
        int len;
        evt_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (hold_off_req) begin
                evt_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            r = $urandom_range(0, 99);
            if (r < 55) begin
                evt_ch.ready <= 1'b1;
                len = $urandom_range(1, 8);
            end else if (r < 62) begin
                evt_ch.ready <= 1'b1;
                len = $urandom_range(40, 150);
            end else if (r < 90) begin
                evt_ch.ready <= 1'b0;
                len = $urandom_range(1, 3);
            end else if (r < 98) begin
                evt_ch.ready <= 1'b0;
                len = $urandom_range(4, 12);
            end else begin
                evt_ch.ready <= 1'b0;
                len = $urandom_range(20, 30);
            end
            repeat (len) @(negedge clk);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gap_mode == GAPS_NONE) return 0;
        if (gap_mode == GAPS_CALM) return (r < 12) ? 1 : 0;
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input bit first, input bit last,
                             input bit known, input bit has_ev, input t_event ev);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            rec_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rec_ch.valid      <= 1'b1;
        rec_ch.data_byte  <= b;
        rec_ch.first_byte <= first;
        rec_ch.last_byte  <= last;
        in_known          <= known;
        in_has_ev         <= has_ev;
        in_ev             <= ev;
        do @(posedge clk); while (!rec_ch.ready);
        @(negedge clk);
    endtask

    task automatic wait_all_events();
        rec_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_events.size() != 0) @(negedge clk);
    endtask

    task automatic plan_byte(input logic [7:0] b, input bit first, input bit last);
        t_script_row row;
        row = '{data: b, first: first, last: last, known: 1'b0, has_ev: 1'b0, ev: '0};
        script_q.push_back(row);
    endtask

    task automatic plan_known(input logic [7:0] b, input bit first, input bit last,
                              input bit has_ev, input t_event ev);
        t_script_row row;
        row = '{data: b, first: first, last: last, known: 1'b1, has_ev: has_ev, ev: ev};
        script_q.push_back(row);
    endtask

    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 199);
        if (r < 30) return 0;
        if (r < 190) return $urandom_range(1, 4);
        if (r < 199) return $urandom_range(5, 20);
        return 255;
    endfunction

    task automatic send_random_record();
        logic [7:0] body[$];
        logic [7:0] op;
        int         n_fields;
        int         cnt;
        int         per;
        int         cut;
        int         r;
        bit         lead_first;
        cut = -1;
        lead_first = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 19) == 0) begin
            // raw noise
            repeat ($urandom_range(1, 20)) body.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 1) cut = $urandom_range(0, body.size() - 1);
        end else begin
            n_fields = $urandom_range(0, 6);
            repeat (n_fields) begin
                cnt = 1;
                case ($urandom_range(0, 7))
                    0: op = OP_BODY;
                    1: op = OP_MODEL16;
                    2: op = OP_NOSEL;
                    3: op = OP_MODEL32;
                    4: op = OP_RECOLOR;
                    5: op = OP_RETEX;
                    6: op = OP_SLOT16_FIRST + 8'($urandom_range(0, 9));
                    default: op = OP_SLOT32_FIRST + 8'($urandom_range(0, 9));
                endcase
                body.push_back(op);
                if (op == OP_NOSEL) per = 0;
                else if (op == OP_RECOLOR || op == OP_RETEX) per = 4;
                else per = value_bytes(op[6:0]);
                if (is_list(op)) begin
                    cnt = pick_count();
                    body.push_back(8'(cnt));
                end
                repeat (cnt * per) body.push_back(rand_byte());
            end
            r = $urandom_range(0, 99);
            if (r < 65) begin
                body.push_back(OP_END);
            end else if (r < 75) begin
                do op = 8'($urandom_range(0, 255));
                while (op == OP_END || op == OP_BODY || op == OP_NOSEL || is_list(op) ||
                       (op >= OP_SLOT16_FIRST && op <= OP_SLOT32_LAST));
                body.push_back(op);
            end else if (r < 80) begin
                body.push_back(OP_END);
                cut = body.size() - 1;
            end else begin
                if (body.size() == 0) body.push_back(rand_byte());
                cut = $urandom_range(0, body.size() - 1);
                body = body[0:cut];
            end
            // trailing bytes past the end of the record
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3)) body.push_back(8'($urandom_range(0, 255)));
        end
        gap_mode = ($urandom_range(0, 3) == 0) ? GAPS_NONE : GAPS_NORMAL;
        foreach (body[i])
            send_byte(body[i], i == 0 ? lead_first : ($urandom_range(0, 99) == 0),
                      i == cut, 1'b0, 1'b0, '0);
    endtask

    initial begin : stimulus
        int rec_n;
        rst_n             = 1'b0;
        rec_ch.valid      = 1'b0;
        rec_ch.data_byte  = '0;
        rec_ch.first_byte = 1'b0;
        rec_ch.last_byte  = 1'b0;
        in_known          = 1'b0;
        in_has_ev         = 1'b0;
        in_ev             = '0;
        parsed_bytes      = 0;
        n_fail            = 0;
        hold_off_req      = 1'b0;
        gap_mode          = GAPS_NORMAL;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // record straight after reset, no first_byte
        plan_known(OP_NOSEL, 0, 0, 1, make_event(EV_NOSEL, 0, 0, 0, 0, 0));
        plan_byte(OP_BODY, 0, 0);
        plan_known(8'hFF, 0, 0, 1, make_event(EV_BODY, 0, 0, 255, 0, 0));
        plan_byte(OP_MODEL16, 0, 0);
        plan_byte(8'h00, 0, 0);                       // empty list
        plan_byte(OP_RECOLOR, 0, 0);
        plan_byte(8'h00, 0, 0);                       // empty list
        plan_known(OP_END, 0, 0, 1, make_event(EV_END, 0, 0, 0, 0, 8));
        plan_known(8'h2A, 0, 0, 0, '0);               // dropped, parser halted
        // 32-bit id, slot 9, then an unknown opcode
        plan_byte(OP_MODEL32, 1, 0);
        plan_byte(8'h01, 0, 0);
        plan_byte(8'hFF, 0, 0);
        plan_byte(8'hFF, 0, 0);
        plan_byte(8'hFF, 0, 0);
        plan_known(8'hFF, 0, 0, 1, make_event(EV_MODEL, 0, 1, 32'hFFFF_FFFF, 0, 0));
        plan_byte(OP_SLOT16_LAST, 0, 0);
        plan_byte(8'h80, 0, 0);
        plan_byte(8'h01, 0, 0);
        plan_known(8'h7F, 0, 0, 1, make_event(EV_UNKNOWN, 0, 0, 0, 0, 10));
        // retexture pair landing on the final byte
        plan_byte(OP_RETEX, 1, 0);
        plan_byte(8'h01, 0, 0);
        plan_byte(8'hAB, 0, 0);
        plan_byte(8'hCD, 0, 0);
        plan_byte(8'h00, 0, 0);
        plan_byte(8'h00, 0, 1);
        // payload cut short, then buffer end after an empty list
        plan_byte(OP_SLOT32_FIRST, 1, 0);
        plan_known(8'h12, 0, 1, 1, make_event(EV_TRUNC, 0, 0, 0, 0, 2));
        plan_byte(OP_MODEL16, 1, 0);
        plan_known(8'h00, 0, 1, 1, make_event(EV_BUFEND, 0, 0, 0, 0, 2));

        @(negedge clk);
        foreach (script_q[i])
            send_byte(script_q[i].data, script_q[i].first, script_q[i].last,
                      script_q[i].known, script_q[i].has_ev, script_q[i].ev);
        wait_all_events();

        for (rec_n = 0; parsed_bytes < RANDOM_BYTES; rec_n++) begin
            if (rec_n == 8 || rec_n == 70) hold_off_req = 1'b1;
            if (rec_n % 25 == 24) wait_all_events();
            send_random_record();
        end

        wait_all_events();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_fail == 0)
            $display("[opcode_record_parser] OK");
        else
            $display("[opcode_record_parser] ERROR");
        $finish;
    end

endmodule
